// ----- hw/rtl/scrolling_text_marquee_top_assert.svh -----
// Assertion macros for the scrolling text marquee block.
// Used by the front and back modules; expects signals clk and arst_n in scope.
`ifndef SCROLLING_TEXT_MARQUEE_TOP_ASSERT_SVH
`define SCROLLING_TEXT_MARQUEE_TOP_ASSERT_SVH

`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define STM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// Consequent checked in the cycle after the antecedent holds.
`define STM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STM_ASSERT(lbl, prop, msg)
`define STM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/marq_pkg.sv -----
// Shared constants, types and tables of the scrolling text marquee.
// Used by marq_front, marq_fifo, marq_back and the top level; no dependencies.
`default_nettype none

package marq_pkg;

	// Display geometry and message storage.
	localparam int Modules       = 4;
	localparam int MessageDepth  = 64;
	localparam int DisplayWidth  = Modules * 8;
	localparam int ColW          = 5;
	localparam int MsgAddrW      = $clog2(MessageDepth);
	localparam int LeadW         = $clog2(DisplayWidth + 1);
	localparam int LenW          = 7;
	localparam int PosW          = 10;
	localparam int ElapsedW      = 9;
	localparam int GlyphColW     = 3;
	localparam int CodeW         = 8;
	localparam int CharIdxW      = 6;
	localparam int InDataW       = 16;
	localparam int OutDataW      = 16;
	localparam int CfgIdxW       = 2;
	localparam int CfgDataW      = 7;
	localparam int QueueDepth    = 2;
	localparam int BlinkFitLen   = (DisplayWidth + 5) / 6;

	localparam logic [ElapsedW-1:0] ElapsedMax = '1;
	localparam logic [GlyphColW-1:0] GlyphGapCol = 3'd5;

	// Operation codes of an input transaction.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Display modes; the unused code behaves as off.
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_SCROLL = 2'd1;
	localparam logic [1:0] MODE_BLINK  = 2'd2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_MODE   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SPEED  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LENGTH = 2'd2;

	// One frame to draw: blank lead-in columns, then text from the given
	// character and glyph column onward.
	typedef struct packed {
		logic [LeadW-1:0]     lead;
		logic [LenW-1:0]      char_pos;
		logic [GlyphColW-1:0] glyph_col;
		logic                 lit;
	} frame_cmd_t;

	// Message store write from the front.
	typedef struct packed {
		logic                en;
		logic [MsgAddrW-1:0] addr;
		logic [CodeW-1:0]    code;
	} msg_wr_t;

	// Back status seen by the front.
	typedef struct packed {
		logic busy;
	} back_status_t;

	// Step intervals in ms indexed by speed level.
	localparam logic [ElapsedW-1:0] ScrollInterval [16] = '{
		9'd128, 9'd118, 9'd108, 9'd99, 9'd89, 9'd80, 9'd70, 9'd60,
		9'd51, 9'd41, 9'd32, 9'd22, 9'd15, 9'd15, 9'd15, 9'd15
	};
	localparam logic [ElapsedW-1:0] BlinkInterval [16] = '{
		9'd320, 9'd296, 9'd272, 9'd248, 9'd224, 9'd200, 9'd176, 9'd152,
		9'd128, 9'd104, 9'd80, 9'd56, 9'd32, 9'd15, 9'd15, 9'd15
	};

	// 5x7 font for codes 32..95, glyph column 0 in the top byte.
	localparam logic [39:0] Font [64] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040
	};

	// Display column bits of one glyph column; codes outside the font are blank.
	function automatic logic [7:0] render_column(logic [CodeW-1:0] code,
			logic [GlyphColW-1:0] gcol);
		logic [39:0] g;
		logic [7:0]  b;
		logic [7:0]  o;
		logic [5:0]  idx;
		o   = '0;
		b   = '0;
		idx = '0;
		g   = '0;
		if (code >= 8'd32 && code <= 8'd95) begin
			idx = 6'(code - 8'd32);
			g   = Font[idx];
			case (gcol)
				3'd0:    b = g[39:32];
				3'd1:    b = g[31:24];
				3'd2:    b = g[23:16];
				3'd3:    b = g[15:8];
				3'd4:    b = g[7:0];
				default: b = '0;
			endcase
			// Glyph row y lights display row 7-y.
			for (int y = 0; y < 7; y++) begin
				o[7-y] = b[y];
			end
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/marq_fifo.sv -----
// Short frame command queue between the front and the back of the marquee.
// Depends on marq_pkg for the entry type and depth.
`default_nettype none

module marq_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire marq_pkg::frame_cmd_t push_data,
	input  wire logic                pop,
	output      marq_pkg::frame_cmd_t pop_data,
	output      logic                full,
	output      logic                empty
);

	localparam int PtrW = $clog2(marq_pkg::QueueDepth);
	localparam int CntW = $clog2(marq_pkg::QueueDepth + 1);

	marq_pkg::frame_cmd_t entry_q [marq_pkg::QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CntW'(marq_pkg::QueueDepth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(marq_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(marq_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/marq_front.sv -----
// Front of the marquee: configuration, tick timing, scroll and blink state.
// Accepts input transactions and queues frame commands; depends on marq_pkg.
`default_nettype none

module marq_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [marq_pkg::InDataW-1:0]  s_tdata,
	input  wire logic                          s_tuser,
	input  wire logic                          cfg_wr_en,
	input  wire logic [marq_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [marq_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic                          q_full,
	input  wire logic                          q_empty,
	input  wire marq_pkg::back_status_t        back_status,
	output      logic                          q_push,
	output      marq_pkg::frame_cmd_t          q_data,
	output      marq_pkg::msg_wr_t             msg_wr,
	output      logic [marq_pkg::LenW-1:0]     msg_length
);

`include "scrolling_text_marquee_top_assert.svh"

	logic [1:0]                       mode_q;
	logic [3:0]                       speed_q;
	logic [marq_pkg::LenW-1:0]        length_q;
	logic signed [marq_pkg::PosW-1:0] pos_q;
	logic [marq_pkg::LenW-1:0]        char_pos_q;
	logic [marq_pkg::GlyphColW-1:0]   glyph_col_q;
	logic [marq_pkg::ElapsedW-1:0]    elapsed_q;
	logic                             blink_q;

	logic                             accept;
	logic                             is_load;
	logic                             tick_acc;
	logic                             active;
	logic                             fire;
	logic [marq_pkg::ElapsedW-1:0]    interval;
	logic [marq_pkg::ElapsedW-1:0]    elapsed_inc;
	logic                             cfg_hit;
	logic [marq_pkg::LenW-1:0]        char_pos_n;
	logic [marq_pkg::GlyphColW-1:0]   glyph_col_n;
	logic                             wrap;
	logic [8:0]                       len_x3;
	logic [marq_pkg::LeadW-1:0]       blink_lead;

	// Loads wait until no queued or running frame still reads the store.
	assign is_load  = (s_tuser == marq_pkg::OP_LOAD);
	assign s_tready = is_load ? (q_empty && !back_status.busy) : !q_full;
	assign accept   = s_tvalid && s_tready;
	assign tick_acc = accept && !is_load;

	assign msg_wr.en   = accept && is_load;
	assign msg_wr.addr = s_tdata[marq_pkg::MsgAddrW-1:0];
	assign msg_wr.code = s_tdata[marq_pkg::CharIdxW +: marq_pkg::CodeW];
	assign msg_length  = length_q;

	// Interval lookup and tick counting.
	assign active   = (mode_q == marq_pkg::MODE_SCROLL) || (mode_q == marq_pkg::MODE_BLINK);
	assign interval = (mode_q == marq_pkg::MODE_BLINK) ? marq_pkg::BlinkInterval[speed_q]
	                                                   : marq_pkg::ScrollInterval[speed_q];
	assign elapsed_inc = (elapsed_q == marq_pkg::ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
	assign fire        = tick_acc && active && (elapsed_inc >= interval);

	// Scroll advance: once the text start is at or left of column 0, track
	// the first visible character and glyph column.
	always_comb begin
		if (glyph_col_q == marq_pkg::GlyphGapCol) begin
			glyph_col_n = '0;
			char_pos_n  = char_pos_q + 1'b1;
		end else begin
			glyph_col_n = glyph_col_q + 1'b1;
			char_pos_n  = char_pos_q;
		end
		wrap = (char_pos_n > length_q) || ((char_pos_n == length_q) && (glyph_col_n != '0));
	end

	// Blink placement: centered, or from column 0 when the text is too wide.
	assign len_x3 = 9'({length_q, 1'b0}) + 9'(length_q);
	assign blink_lead = (length_q >= marq_pkg::LenW'(marq_pkg::BlinkFitLen)) ? '0 :
		marq_pkg::LeadW'(marq_pkg::DisplayWidth / 2) - marq_pkg::LeadW'(len_x3);

	// Frame command for the back.
	always_comb begin
		q_push = fire;
		if (mode_q == marq_pkg::MODE_BLINK) begin
			q_data.lead      = blink_lead;
			q_data.char_pos  = '0;
			q_data.glyph_col = '0;
			q_data.lit       = !blink_q;
		end else begin
			q_data.lead      = (pos_q > 0) ? marq_pkg::LeadW'(pos_q) : '0;
			q_data.char_pos  = char_pos_q;
			q_data.glyph_col = glyph_col_q;
			q_data.lit       = 1'b1;
		end
	end

	assign cfg_hit = cfg_wr_en && (cfg_index == marq_pkg::REG_MODE ||
		cfg_index == marq_pkg::REG_SPEED || cfg_index == marq_pkg::REG_LENGTH);

	// Registers and animation state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= marq_pkg::MODE_OFF;
			speed_q     <= 4'd5;
			length_q    <= '0;
			pos_q       <= marq_pkg::PosW'(marq_pkg::DisplayWidth);
			char_pos_q  <= '0;
			glyph_col_q <= '0;
			elapsed_q   <= marq_pkg::ElapsedMax;
			blink_q     <= 1'b0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				marq_pkg::REG_MODE:   mode_q  <= cfg_data[1:0];
				marq_pkg::REG_SPEED:  speed_q <= cfg_data[3:0];
				marq_pkg::REG_LENGTH: begin
					length_q <= (cfg_data > marq_pkg::LenW'(marq_pkg::MessageDepth)) ?
						marq_pkg::LenW'(marq_pkg::MessageDepth) : cfg_data;
				end
				default: ;
			endcase
			pos_q       <= marq_pkg::PosW'(marq_pkg::DisplayWidth);
			char_pos_q  <= '0;
			glyph_col_q <= '0;
			elapsed_q   <= marq_pkg::ElapsedMax;
			blink_q     <= 1'b0;
		end else if (tick_acc && active) begin
			elapsed_q <= fire ? '0 : elapsed_inc;
			if (fire && mode_q == marq_pkg::MODE_BLINK) begin
				blink_q <= !blink_q;
			end else if (fire) begin
				if (pos_q > 0) begin
					pos_q <= pos_q - 1'b1;
				end else if (wrap) begin
					pos_q       <= marq_pkg::PosW'(marq_pkg::DisplayWidth);
					char_pos_q  <= '0;
					glyph_col_q <= '0;
				end else begin
					pos_q       <= pos_q - 1'b1;
					char_pos_q  <= char_pos_n;
					glyph_col_q <= glyph_col_n;
				end
			end
		end
	end

	// A load never overlaps a frame that still reads the message store.
	`STM_ASSERT(a_load_when_idle, msg_wr.en |-> (q_empty && !back_status.busy), "load during frame")
	// A fired frame always finds room in the queue.
	`STM_ASSERT(a_fire_has_room, q_push |-> !q_full, "frame command lost")

endmodule

`default_nettype wire

// ----- hw/rtl/marq_back.sv -----
// Back of the marquee: message store, column sequencer, output register; uses marq_pkg.
// Draws one queued frame at a time, one column per cycle unless the output stalls.
`default_nettype none

module marq_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_empty,
	input  wire marq_pkg::frame_cmd_t           q_data,
	output      logic                           q_pop,
	input  wire marq_pkg::msg_wr_t              msg_wr,
	input  wire logic [marq_pkg::LenW-1:0]      msg_length,
	output      marq_pkg::back_status_t         status,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [marq_pkg::OutDataW-1:0]  m_tdata,
	output      logic                           m_tlast
);

`include "scrolling_text_marquee_top_assert.svh"

	localparam logic [marq_pkg::ColW-1:0] LastCol = marq_pkg::ColW'(marq_pkg::DisplayWidth - 1);

	logic [marq_pkg::CodeW-1:0] msg_mem [marq_pkg::MessageDepth];

	// Sequencer state.
	logic                           busy_q;
	logic [marq_pkg::ColW-1:0]      col_q;
	logic [marq_pkg::LeadW-1:0]     lead_q;
	logic [marq_pkg::LenW-1:0]      char_pos_q;
	logic [marq_pkg::GlyphColW-1:0] glyph_col_q;
	logic                           lit_q;

	// Read stage.
	logic                           valid_s1;
	logic [marq_pkg::ColW-1:0]      col_s1;
	logic                           show_s1;
	logic [marq_pkg::GlyphColW-1:0] glyph_col_s1;
	logic                           last_s1;
	logic [marq_pkg::CodeW-1:0]     code_s1;

	// Output register.
	logic                           m_tvalid_q;
	logic [marq_pkg::ColW-1:0]      col_q_out;
	logic [7:0]                     bits_q;
	logic                           last_q;

	logic                           adv;
	logic                           issue;
	logic                           in_text;
	logic                           show;

	assign adv     = !m_tvalid_q || m_tready;
	assign issue   = busy_q && adv;
	assign q_pop   = !busy_q && !q_empty;
	assign in_text = (char_pos_q < msg_length);
	assign show    = lit_q && (lead_q == '0) && in_text && (glyph_col_q != marq_pkg::GlyphGapCol);
	assign status.busy = busy_q;

	// Column sequencer: lead-in blanks, then glyph columns with a gap column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			col_q       <= '0;
			lead_q      <= '0;
			char_pos_q  <= '0;
			glyph_col_q <= '0;
			lit_q       <= 1'b0;
		end else if (q_pop) begin
			busy_q      <= 1'b1;
			col_q       <= '0;
			lead_q      <= q_data.lead;
			char_pos_q  <= q_data.char_pos;
			glyph_col_q <= q_data.glyph_col;
			lit_q       <= q_data.lit;
		end else if (issue) begin
			col_q <= col_q + 1'b1;
			if (col_q == LastCol) begin
				busy_q <= 1'b0;
			end
			if (lead_q != '0) begin
				lead_q <= lead_q - 1'b1;
			end else if (in_text) begin
				if (glyph_col_q == marq_pkg::GlyphGapCol) begin
					glyph_col_q <= '0;
					char_pos_q  <= char_pos_q + 1'b1;
				end else begin
					glyph_col_q <= glyph_col_q + 1'b1;
				end
			end
		end
	end

	// Message store write port.
	always_ff @(posedge clk) begin
		if (msg_wr.en) begin
			msg_mem[msg_wr.addr] <= msg_wr.code;
		end
	end

	// Message store read port, registered into the read stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			code_s1      <= msg_mem[char_pos_q[marq_pkg::MsgAddrW-1:0]];
			col_s1       <= col_q;
			show_s1      <= show;
			glyph_col_s1 <= glyph_col_q;
			last_s1      <= (col_q == LastCol);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	// Output register: font lookup of the read character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_q_out <= col_s1;
			bits_q    <= show_s1 ? marq_pkg::render_column(code_s1, glyph_col_s1) : 8'd0;
			last_q    <= last_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, bits_q, col_q_out};
	assign m_tlast  = last_q;

	// A frame starts at column 0 right after its command leaves the queue.
	`STM_ASSERT_NEXT(a_pop_starts, q_pop, (busy_q && col_q == '0), "frame start lost")
	// The sequencer stops after issuing the last column.
	`STM_ASSERT_NEXT(a_last_stops, (issue && col_q == LastCol), !busy_q, "frame overrun")
	// A read-stage column always reaches the output register.
	`STM_ASSERT_NEXT(a_s1_to_out, (valid_s1 && adv), m_tvalid_q, "column dropped")

endmodule

`default_nettype wire

// ----- hw/rtl/scrolling_text_marquee_top.sv -----
// Scrolling text marquee for a row of 8x8 LED modules with a 5x7 font.
// Input channel (s_*): one transaction is a millisecond tick or a message
//   character load; tuser selects which, tdata carries the load's fields.
// Output channel (m_*): one transaction per display column, left to right,
//   32 per frame, tlast on the final column.
// Configuration: plain write port for mode, speed and message length; a write
//   to any of these restarts the animation, and the next tick then makes a frame.
// A firing tick's frame command passes through the frame queue, the column
//   sequencer, the read stage and the output register; a frame then streams
//   one column per cycle while the receiver is ready.
// Ticks are taken every cycle while the two-entry frame queue has room; a
//   load waits until no queued or running frame still reads the store.
// Reset: mode off, speed 5, length 0, the text starts right of the display.
// When the receiver stalls, the column pipeline holds; frames then wait in
//   the queue and ticks stall once it is full.
`default_nettype none

module scrolling_text_marquee_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Slave input stream.
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [marq_pkg::InDataW-1:0]  s_tdata,   // char_index[5:0], char_code[13:6]
	input  wire logic                          s_tuser,   // operation
	// Master output stream.
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	output      logic [marq_pkg::OutDataW-1:0] m_tdata,   // column_index[4:0], column_bits[12:5]
	output      logic                          m_tlast,   // last_column
	// Configuration write port.
	input  wire logic                          cfg_wr_en,
	input  wire logic [marq_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [marq_pkg::CfgDataW-1:0] cfg_data
);

	logic                      q_push;
	logic                      q_pop;
	logic                      q_full;
	logic                      q_empty;
	marq_pkg::frame_cmd_t      q_wr_data;
	marq_pkg::frame_cmd_t      q_rd_data;
	marq_pkg::msg_wr_t         msg_wr;
	marq_pkg::back_status_t    back_status;
	logic [marq_pkg::LenW-1:0] msg_length;

	// Front: configuration, tick timing and frame commands.
	marq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.q_empty     (q_empty),
		.back_status (back_status),
		.q_push      (q_push),
		.q_data      (q_wr_data),
		.msg_wr      (msg_wr),
		.msg_length  (msg_length)
	);

	// Frame command queue.
	marq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wr_data),
		.pop       (q_pop),
		.pop_data  (q_rd_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: message store and column rendering.
	marq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_rd_data),
		.q_pop      (q_pop),
		.msg_wr     (msg_wr),
		.msg_length (msg_length),
		.status     (back_status),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire
